/* rtl/llfl_pkg.sv */
`default_nettype none

package llfl_pkg;

  // Field widths of the command and result words
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 64;
  localparam int PAY_W  = 64;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;

  // Most entries that one list command reports
  localparam int LIST_CAP = 16;

  typedef enum logic [CMD_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_APP_RD,
    BK_APP_WR,
    BK_APP_LINK,
    BK_DEL_RD,
    BK_DEL_CMP,
    BK_DEL_UNLINK,
    BK_DEL_FREE,
    BK_LST_RD,
    BK_LST_CAP,
    BK_EMIT
  } back_state_t;

  // Classified command word passed from front to back
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/llfl_chan_if.sv */
`default_nettype none

// Command channel
interface llfl_in_if;
  import llfl_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, output command, output key, output payload, input ready);
  modport sink   (input valid, input command, input key, input payload, output ready);
endinterface

// Result channel
interface llfl_out_if;
  import llfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot;
  logic [KEY_W-1:0]  entry_key;
  logic [PAY_W-1:0]  entry_payload;
  logic              last;

  modport source (output valid, output status, output slot, output entry_key,
                  output entry_payload, output last, input ready);
  modport sink   (input valid, input status, input slot, input entry_key,
                  input entry_payload, input last, output ready);
endinterface

`default_nettype wire

/* rtl/llfl_ram.sv */
`default_nettype none

module llfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/llfl_front.sv */
`default_nettype none

module llfl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  llfl_in_if.sink            in_ch,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output llfl_pkg::cmd_t     cmd
);
  import llfl_pkg::*;

  localparam int QD = 2;

  cmd_t                   q_r [QD];
  logic [$clog2(QD)-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [$clog2(QD)-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(QD+1)-1:0] cnt_r, cnt_nxt;
  op_t                    op_in;
  logic                   accept;
  logic                   push;
  logic                   pop;

  // Classify the incoming word; drop unused commands here
  assign op_in        = op_t'(in_ch.command);
  assign in_ch.ready  = (cnt_r != ($clog2(QD+1))'(QD));
  assign accept       = in_ch.valid && in_ch.ready;
  assign push         = accept && (op_in != OP_NONE);

  assign cmd_valid    = (cnt_r != '0);
  assign cmd          = q_r[rd_ptr_r];
  assign pop          = cmd_valid && cmd_ready;

  // Advance queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued words
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op_in, key: in_ch.key, payload: in_ch.payload};
    end
  end

endmodule

`default_nettype wire

/* rtl/llfl_back.sv */
`default_nettype none

module llfl_back #(
  parameter int SLOTS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire llfl_pkg::cmd_t cmd,
  llfl_out_if.source         out_ch
);
  import llfl_pkg::*;

  localparam int IW       = $clog2(SLOTS);
  localparam int LW       = $clog2(SLOTS + 1);
  localparam int KPW      = KEY_W + PAY_W;
  localparam int LIST_LIM = (SLOTS < LIST_CAP) ? SLOTS : LIST_CAP;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  back_state_t state_r, state_nxt;

  // Pool bookkeeping
  logic [LW-1:0] list_head_r, list_head_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [LW-1:0] hw_r, hw_nxt;

  // Walk registers
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] next_r, next_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] cnt_inc;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;

  // Pending result
  status_t           res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [PAY_W-1:0]  res_pay_r, res_pay_nxt;
  logic              res_last_r, res_last_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [PAY_W-1:0]  out_pay_r, out_pay_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;

  // Memory ports
  logic [IW-1:0]  rd_addr;
  logic           lk_we;
  logic [IW-1:0]  lk_waddr;
  logic [LW-1:0]  lk_wdata;
  logic [LW-1:0]  lk_rdata;
  logic           kp_we;
  logic [IW-1:0]  kp_waddr;
  logic [KPW-1:0] kp_wdata;
  logic [KPW-1:0] kp_rdata;
  logic           key_hit;

  function automatic logic is_slot(input logic [LW-1:0] v);
    return v < NIL;
  endfunction

  llfl_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (rd_addr),
    .rdata (lk_rdata)
  );

  llfl_ram #(.WIDTH(KPW), .DEPTH(SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (kp_we),
    .waddr (kp_waddr),
    .wdata (kp_wdata),
    .raddr (rd_addr),
    .rdata (kp_rdata)
  );

  assign cnt_inc   = cnt_r + LW'(1);
  assign key_hit   = (kp_rdata[KPW-1:PAY_W] == key_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cmd_ready = (state_r == BK_IDLE);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.slot          = out_slot_r;
  assign out_ch.entry_key     = out_key_r;
  assign out_ch.entry_payload = out_pay_r;
  assign out_ch.last          = out_last_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_APPEND: state_nxt = is_slot(free_head_r) ? BK_APP_RD : BK_EMIT;
            OP_DELETE: state_nxt = BK_DEL_RD;
            OP_LIST:   state_nxt = is_slot(list_head_r) ? BK_LST_RD : BK_EMIT;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_APP_RD:   state_nxt = BK_APP_WR;
      BK_APP_WR:   state_nxt = is_slot(list_head_r) ? BK_APP_LINK : BK_EMIT;
      BK_APP_LINK: state_nxt = BK_EMIT;
      BK_DEL_RD:   state_nxt = is_slot(cur_r) ? BK_DEL_CMP : BK_EMIT;
      BK_DEL_CMP: begin
        if (key_hit) begin
          state_nxt = BK_DEL_UNLINK;
        end else if (!is_slot(lk_rdata) || (cnt_inc == NIL)) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_DEL_UNLINK: state_nxt = BK_DEL_FREE;
      BK_DEL_FREE:   state_nxt = BK_EMIT;
      BK_LST_RD:     state_nxt = BK_LST_CAP;
      BK_LST_CAP:    state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = res_last_r ? BK_IDLE : BK_LST_RD;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    list_head_nxt  = list_head_r;
    free_head_nxt  = free_head_r;
    tail_nxt       = tail_r;
    hw_nxt         = hw_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_last_nxt   = out_last_r;
    rd_addr        = cur_r[IW-1:0];
    lk_we          = 1'b0;
    lk_waddr       = cur_r[IW-1:0];
    lk_wdata       = NIL;
    kp_we          = 1'b0;
    kp_waddr       = cur_r[IW-1:0];
    kp_wdata       = {key_r, pay_r};

    unique case (state_r)
      // Take a command and set up its walk or its early status
      BK_IDLE: begin
        if (cmd_valid) begin
          key_nxt      = cmd.key;
          pay_nxt      = cmd.payload;
          cnt_nxt      = '0;
          cur_nxt      = list_head_r;
          prev_nxt     = NIL;
          res_slot_nxt = '0;
          res_key_nxt  = '0;
          res_pay_nxt  = '0;
          res_last_nxt = 1'b1;
          case (cmd.op)
            OP_APPEND: res_status_nxt = ST_FULL;
            OP_LIST:   res_status_nxt = ST_EMPTY;
            default:   res_status_nxt = ST_NOTFOUND;
          endcase
        end
      end
      // Fetch the link of the free head
      BK_APP_RD: begin
        rd_addr = free_head_r[IW-1:0];
      end
      // Pop the free head, fill the slot, close its link
      BK_APP_WR: begin
        free_head_nxt = (free_head_r < hw_r) ? lk_rdata : free_head_r + LW'(1);
        if (free_head_r == hw_r) begin
          hw_nxt = hw_r + LW'(1);
        end
        lk_we    = 1'b1;
        lk_waddr = free_head_r[IW-1:0];
        lk_wdata = NIL;
        kp_we    = 1'b1;
        kp_waddr = free_head_r[IW-1:0];
        cur_nxt  = free_head_r;
        if (!is_slot(list_head_r)) begin
          list_head_nxt = free_head_r;
          tail_nxt      = free_head_r;
        end
        res_status_nxt = ST_OK;
        res_slot_nxt   = SLOT_W'(free_head_r);
        res_key_nxt    = key_r;
        res_pay_nxt    = pay_r;
        res_last_nxt   = 1'b1;
      end
      // Link the new slot behind the tail
      BK_APP_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = tail_r[IW-1:0];
        lk_wdata = cur_r;
        tail_nxt = cur_r;
      end
      BK_DEL_RD: begin
        rd_addr = cur_r[IW-1:0];
      end
      // Compare one entry per cycle, reading the next one behind it
      BK_DEL_CMP: begin
        if (key_hit) begin
          next_nxt       = lk_rdata;
          res_status_nxt = ST_OK;
          res_slot_nxt   = SLOT_W'(cur_r);
          res_key_nxt    = kp_rdata[KPW-1:PAY_W];
          res_pay_nxt    = kp_rdata[PAY_W-1:0];
        end else if (is_slot(lk_rdata) && (cnt_inc != NIL)) begin
          prev_nxt = cur_r;
          cur_nxt  = lk_rdata;
          cnt_nxt  = cnt_inc;
          rd_addr  = lk_rdata[IW-1:0];
        end
      end
      // Bridge over the removed slot
      BK_DEL_UNLINK: begin
        if (is_slot(prev_r)) begin
          lk_we    = 1'b1;
          lk_waddr = prev_r[IW-1:0];
          lk_wdata = next_r;
        end else begin
          list_head_nxt = next_r;
        end
        if (tail_r == cur_r) begin
          tail_nxt = prev_r;
        end
      end
      // Push the slot onto the free list
      BK_DEL_FREE: begin
        lk_we         = 1'b1;
        lk_waddr      = cur_r[IW-1:0];
        lk_wdata      = free_head_r;
        free_head_nxt = cur_r;
      end
      BK_LST_RD: begin
        rd_addr = cur_r[IW-1:0];
      end
      // Build one listed entry and advance
      BK_LST_CAP: begin
        res_status_nxt = ST_OK;
        res_slot_nxt   = SLOT_W'(cur_r);
        res_key_nxt    = kp_rdata[KPW-1:PAY_W];
        res_pay_nxt    = kp_rdata[PAY_W-1:0];
        res_last_nxt   = !is_slot(lk_rdata) || (cnt_inc == LW'(LIST_LIM));
        cur_nxt        = lk_rdata;
        cnt_nxt        = cnt_inc;
      end
      // Move the result word into the output register
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_key_nxt    = res_key_r;
          out_pay_nxt    = res_pay_r;
          out_last_nxt   = res_last_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      list_head_r <= NIL;
      free_head_r <= '0;
      tail_r      <= NIL;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      tail_r      <= tail_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    cnt_r        <= cnt_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_pop_real_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_APP_RD) |-> (free_head_r < NIL))
    else $error("append pops an empty free list");

  a_free_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r <= hw_r) && (hw_r <= NIL))
    else $error("free head beyond fill count");

  a_head_tail_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (list_head_r == NIL) == (tail_r == NIL))
    else $error("list head and tail disagree on emptiness");
`endif

endmodule

`default_nettype wire

/* rtl/linked_list_free_list_engine.sv */
// Path, word accepted to result word: the front queue, then the back end states. Append reads,
//   writes and, onto a non-empty list, links, then emits; delete compares entries until a hit
//   (then unlinks and frees) or the end; list reads, captures and emits each entry; full or empty emits.
// Throughput: one command at a time in the back end; a delete compares one entry
//   per cycle, a list takes each entry through a read, a capture and an emit state.
// Reset: synchronous, active low; lists empty, free list held by a fill count, no clearing pass.
`default_nettype none

module linked_list_free_list_engine #(
  parameter int SLOTS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  llfl_in_if.sink    in_ch,
  llfl_out_if.source out_ch
);
  import llfl_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  llfl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  llfl_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
